// ----- design/fhd_pkg.sv -----
// ----------------------------------------------------------------------------
// fhd_pkg: shared types and constants for the fire heat diffusion block
// Configuration register indexes, queue entry layout, reciprocal constants
// for the divide by nine, and the fire palette lookup.
// ----------------------------------------------------------------------------
package fhd_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] BUFFER_WIDTH_RESET  = 11'd322;
  localparam logic [CFG_W-1:0] BUFFER_HEIGHT_RESET = 11'd241;

  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 2;

  // depth of the queue between front and back
  localparam int QDEPTH = 4;

  // floor(s / 9) == (s * 3641) >> 15 for every s below 2296
  localparam int SUM_W      = 12;
  localparam int DIV9_MUL   = 3641;
  localparam int DIV9_SHIFT = 15;
  localparam int PROD_W     = 24;

  typedef struct packed {
    logic [7:0] cur_heat;   // old heat of this cell, zero on edge columns
    logic [7:0] self_old;   // old heat of the cell above
    logic [7:0] right_old;  // old heat of the cell above right, zero past the edge
    logic       edge_col;   // first or last column
    logic       above;      // a row above exists: emit the cell above
    logic       bottom;     // bottom row: also pass this cell through
  } entry_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Fire palette ROM: four truncating linear ramps over 64 steps each.
  function automatic rgb_t palette(input logic [7:0] h);
    logic [15:0] i;
    logic [15:0] up96;
    logic [15:0] dn96;
    logic [15:0] up255;
    logic [15:0] mix;
    rgb_t        c;
    i     = {10'd0, h[5:0]};
    up96  = (i * 16'd96) >> 6;
    dn96  = ((16'd64 - i) * 16'd96) >> 6;
    up255 = (i * 16'd255) >> 6;
    mix   = (16'd6144 + i * 16'd159) >> 6;
    case (h[7:6])
      2'd0: begin
        c = '{r: up96[7:0], g: up96[7:0], b: up96[7:0]};
      end
      2'd1: begin
        c = '{r: mix[7:0], g: dn96[7:0], b: dn96[7:0]};
      end
      2'd2: begin
        c = '{r: 8'd255, g: up255[7:0], b: 8'd0};
      end
      default: begin
        c = '{r: 8'd255, g: 8'd255, b: up255[7:0]};
      end
    endcase
    return c;
  endfunction

endpackage

// ----- design/fhd_if.sv -----
// ----------------------------------------------------------------------------
// fhd_if: stream channels of the fire heat diffusion block
// Input channel carries one old heat byte per transaction; output channel
// carries one emitted cell with its palette color.
// ----------------------------------------------------------------------------
interface fhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] heat_in;

  modport source (output valid, output heat_in, input ready);
  modport sink   (input valid, input heat_in, output ready);
endinterface

interface fhd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] heat_out;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       visible;
  logic       last_of_run;

  modport source (output valid, output heat_out, output red, output green,
                  output blue, output visible, output last_of_run, input ready);
  modport sink   (input valid, input heat_out, input red, input green,
                  input blue, input visible, input last_of_run, output ready);
endinterface

// ----- design/fhd_front.sv -----
// ----------------------------------------------------------------------------
// fhd_front: input side of the fire heat diffusion block
// Holds the configuration, tracks column and row, zeroes edge cells, keeps
// the previous row in a line memory and pushes classified cells to the queue.
// ----------------------------------------------------------------------------
module fhd_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fhd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fhd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     heat_in,
  output logic                           push,
  output fhd_pkg::entry_t                push_data,
  input  logic                           q_full
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [fhd_pkg::CFG_W-1:0] buffer_width;
  logic [fhd_pkg::CFG_W-1:0] buffer_height;
  logic [CW-1:0]             w_last;
  logic [RW-1:0]             h_last;
  logic [CW-1:0]             col;
  logic [RW-1:0]             row;
  logic [CW-1:0]             rd_addr;
  logic                      accept;
  logic                      edge_now;
  logic [7:0]                cell_now;

  logic [7:0]                row_store [MAX_WIDTH];
  logic [7:0]                rdata;
  logic [7:0]                prev_raw;

  logic                      s_valid;
  logic [7:0]                s_cell;
  logic                      s_edge;
  logic                      s_right_ok;
  logic                      s_above;
  logic                      s_bottom;

  // saturate the registers into the supported frame size
  always_comb begin
    if (buffer_width < fhd_pkg::CFG_W'(fhd_pkg::MIN_WIDTH)) begin
      w_last = CW'(fhd_pkg::MIN_WIDTH - 1);
    end else if (32'(buffer_width) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(buffer_width - 11'd1);
    end
    if (buffer_height < fhd_pkg::CFG_W'(fhd_pkg::MIN_HEIGHT)) begin
      h_last = RW'(fhd_pkg::MIN_HEIGHT - 1);
    end else if (32'(buffer_height) > MAX_HEIGHT) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(buffer_height - 11'd1);
    end
  end

  assign push     = s_valid && !q_full;
  assign in_ready = !s_valid || !q_full;
  assign accept   = in_valid && in_ready;
  assign edge_now = (col == '0) || (col == w_last);
  assign cell_now = edge_now ? 8'd0 : heat_in;
  assign rd_addr  = col + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_width  <= fhd_pkg::BUFFER_WIDTH_RESET;
      buffer_height <= fhd_pkg::BUFFER_HEIGHT_RESET;
      col           <= '0;
      row           <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fhd_pkg::REG_BUFFER_WIDTH:  buffer_width  <= cfg_data;
        fhd_pkg::REG_BUFFER_HEIGHT: buffer_height <= cfg_data;
        default: ;
      endcase
      // restart the frame
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Write this cell, read the one above right; the cell above comes from the
  // previous transaction's read.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_store[col] <= cell_now;
      rdata          <= row_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (push) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_cell     <= cell_now;
      s_edge     <= edge_now;
      s_right_ok <= ({1'b0, col} + (CW+1)'(1)) < {1'b0, w_last};
      s_above    <= (row != '0);
      s_bottom   <= (row == h_last);
    end
    if (push) begin
      prev_raw <= rdata;
    end
  end

  always_comb begin
    push_data.cur_heat  = s_cell;
    push_data.self_old  = prev_raw;
    push_data.right_old = s_right_ok ? rdata : 8'd0;
    push_data.edge_col  = s_edge;
    push_data.above     = s_above;
    push_data.bottom    = s_bottom;
  end

endmodule

// ----- design/fhd_queue.sv -----
// ----------------------------------------------------------------------------
// fhd_queue: short queue of classified cells between front and back
// Small circular buffer; lets each side stall without at once blocking the other.
// ----------------------------------------------------------------------------
module fhd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fhd_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output fhd_pkg::entry_t head,
  output logic            empty
);

  localparam int PW = $clog2(fhd_pkg::QDEPTH);
  localparam int NW = $clog2(fhd_pkg::QDEPTH + 1);

  fhd_pkg::entry_t slots [fhd_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   count;

  assign full  = (count == NW'(fhd_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(fhd_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(fhd_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

// ----- design/fhd_back.sv -----
// ----------------------------------------------------------------------------
// fhd_back: result side of the fire heat diffusion block
// Runs the in-place diffusion recurrence, emits zero, one or two results per
// queued cell through an output register, and maps heat to the fire palette.
// ----------------------------------------------------------------------------
module fhd_back (
  input  logic            clk,
  input  logic            rst,
  input  fhd_pkg::entry_t head,
  input  logic            q_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      heat_out,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic            visible,
  output logic            last_of_run
);

  logic [7:0]                   left;
  logic                         second;
  logic                         second_next;
  logic                         o_valid;
  logic [7:0]                   o_heat;
  logic                         o_visible;
  logic                         o_last;
  logic                         can_load;
  logic                         load;
  logic                         upd_left;
  logic [7:0]                   sel_heat;
  logic                         sel_visible;
  logic                         sel_last;
  logic [fhd_pkg::SUM_W-1:0]    sum;
  logic [fhd_pkg::PROD_W-1:0]   prod;
  logic [7:0]                   v;
  fhd_pkg::rgb_t                rgb;

  // new heat = (new left + old self + old right + 6 * old below) / 9
  always_comb begin
    sum  = fhd_pkg::SUM_W'(left) + fhd_pkg::SUM_W'(head.self_old)
         + fhd_pkg::SUM_W'(head.right_old)
         + fhd_pkg::SUM_W'(head.cur_heat) * fhd_pkg::SUM_W'(6);
    prod = fhd_pkg::PROD_W'(sum) * fhd_pkg::PROD_W'(fhd_pkg::DIV9_MUL);
    v    = head.edge_col ? 8'd0 : prod[fhd_pkg::DIV9_SHIFT +: 8];
  end

  assign can_load = !o_valid || out_ready;

  always_comb begin
    pop         = 1'b0;
    load        = 1'b0;
    upd_left    = 1'b0;
    second_next = second;
    sel_heat    = head.cur_heat;
    sel_visible = 1'b0;
    sel_last    = 1'b1;
    if (!q_empty) begin
      if (!head.above && !head.bottom) begin
        // top row: nothing to emit
        pop = 1'b1;
      end else if (can_load) begin
        load = 1'b1;
        if (head.above && !second) begin
          sel_heat    = v;
          sel_visible = !head.edge_col;
          sel_last    = !head.bottom;
          upd_left    = 1'b1;
          if (head.bottom) begin
            second_next = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          // bottom cell passes through
          pop         = 1'b1;
          second_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      second  <= 1'b0;
      left    <= 8'd0;
    end else begin
      if (load) begin
        o_valid <= 1'b1;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end
      second <= second_next;
      if (upd_left) begin
        left <= v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_heat    <= sel_heat;
      o_visible <= sel_visible;
      o_last    <= sel_last;
    end
  end

  assign rgb         = fhd_pkg::palette(o_heat);
  assign out_valid   = o_valid;
  assign heat_out    = o_heat;
  assign red         = rgb.r;
  assign green       = rgb.g;
  assign blue        = rgb.b;
  assign visible     = o_visible;
  assign last_of_run = o_last;

  a_second_pending: assert property (@(posedge clk) disable iff (rst)
    second |-> (o_valid && !q_empty))
    else $error("bottom pass-through pending without a held result or queued cell");

  a_second_bottom: assert property (@(posedge clk) disable iff (rst)
    second |-> (head.above && head.bottom))
    else $error("pass-through pending on a cell that is not in the bottom row");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_visible && !o_last) |-> (o_heat == 8'd0))
    else $error("hidden non-final result carries nonzero heat");

endmodule

// ----- design/fire_heat_diffusion_palette_top.sv -----
// ----------------------------------------------------------------------------
// fire_heat_diffusion_palette_top: fire effect heat blur with palette lookup
// Streams one frame of heat bytes in raster order and emits diffused heat
// with its fire palette color.
// ----------------------------------------------------------------------------
// The block takes one heat byte per clock in raster order while the queue is
// not full, and emits each row one row late, since a cell's new value needs
// the cell below it. The top row yields no result, middle rows one result
// per input, and the bottom row two results per input, so there the single
// output register sets the pace. From input to result a cell passes the line
// memory read, the queue and the output register. A four-entry queue
// separates the input side from the result side, so a stalled output
// does not stop input at once. Any write to buffer_width or buffer_height
// restarts the frame at row 0; the line memory needs no clearing after
// reset, since the top row of every frame refills it before it is read.
// ----------------------------------------------------------------------------
module fire_heat_diffusion_palette_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fhd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fhd_pkg::CFG_W-1:0]     cfg_data,
  fhd_in_if.sink                        pix_in,
  fhd_out_if.source                     pix_out
);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  fhd_pkg::entry_t push_data;
  fhd_pkg::entry_t head;

  fhd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .heat_in   (pix_in.heat_in),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  fhd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  fhd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .heat_out    (pix_out.heat_out),
    .red         (pix_out.red),
    .green       (pix_out.green),
    .blue        (pix_out.blue),
    .visible     (pix_out.visible),
    .last_of_run (pix_out.last_of_run)
  );

endmodule
